FILE: rtl/core/abkvs_pkg.sv
// ----------------------------------------------------------------------------
// abkvs_pkg
// Shared types and constants of the array binary search tree key/value store.
// ----------------------------------------------------------------------------
package abkvs_pkg;

	// Tree geometry and stored value width
	localparam int NODES       = 64;
	localparam int VALUE_WIDTH = 32;

	// Fixed widths of the channel fields
	localparam int MODE_W    = 2;
	localparam int KEY_W     = 32;
	localparam int DATA_W    = 32;
	localparam int ENTRIES_W = 7;

	// Derived widths
	localparam int IDX_W   = $clog2(NODES);
	localparam int NEXT_W  = IDX_W + 2;
	localparam int COUNT_W = $clog2(NODES + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT    = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	// Write port of the node memory
	typedef struct packed {
		logic                    en;
		logic [IDX_W-1:0]        addr;
		logic signed [KEY_W-1:0] key;
		logic [VALUE_WIDTH-1:0]  value;
	} mem_wr_t;

endpackage

FILE: rtl/core/abkvs_req_if.sv
// ----------------------------------------------------------------------------
// abkvs_req_if
// Request channel: operation code, key and value, with valid/ready.
// ----------------------------------------------------------------------------
interface abkvs_req_if;
	import abkvs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic signed [KEY_W-1:0] key;
	logic [DATA_W-1:0]       value;

	modport source (output valid, output mode, output key, output value, input ready);
	modport sink   (input valid, input mode, input key, input value, output ready);

endinterface

FILE: rtl/core/abkvs_rsp_if.sv
// ----------------------------------------------------------------------------
// abkvs_rsp_if
// Response channel: status flags, looked-up value and live count, with valid/ready.
// ----------------------------------------------------------------------------
interface abkvs_rsp_if;
	import abkvs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic                 full_res;
	logic [DATA_W-1:0]    found_value;
	logic [ENTRIES_W-1:0] entries;

	modport source (output valid, output ok, output full_res, output found_value,
		output entries, input ready);
	modport sink   (input valid, input ok, input full_res, input found_value,
		input entries, output ready);

endinterface

FILE: rtl/core/array_bst_key_value_store_unit.sv
// ----------------------------------------------------------------------------
// array_bst_key_value_store_unit
// Key/value map held as a binary search tree laid out in a node array, where
// the children of node i are 2i+1 (smaller keys) and 2i+2 (larger keys).
// ----------------------------------------------------------------------------
//
//  channel | dir | beat fields                          | taken when
//  --------+-----+--------------------------------------+-------------------
//  req     | in  | mode, key, value                     | req.valid & ready
//  rsp     | out | ok, full_res, found_value, entries   | rsp.valid & ready
//
// A beat visits 1 to 7 tree levels for 64 nodes, and mode 3 only the root. The
// walk reads one node per cycle from the single read port of the node memory.
// Reset clears the used and tombstone bits and the live count at once; key and
// value storage needs no clearing, so the block takes a beat right after reset.
// A finished result sits in the rsp register; while that register is full and
// rsp.ready is low, a finished walk holds and commits nothing until it frees.
// ----------------------------------------------------------------------------
module array_bst_key_value_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	abkvs_req_if.sink   req,
	abkvs_rsp_if.source rsp
);
	import abkvs_pkg::*;

	// Sequencer state
	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	// Latched request
	mode_t                   mode_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VALUE_WIDTH-1:0]  value_q;

	// Node flags and live count
	logic [NODES-1:0]   used_q;
	logic [NODES-1:0]   removed_q;
	logic [COUNT_W-1:0] count_q, count_d;

	// Node memory
	mem_wr_t                 mem_wr;
	logic [IDX_W-1:0]        rd_addr;
	logic signed [KEY_W-1:0] rd_key;
	logic [VALUE_WIDTH-1:0]  rd_value;

	// Response register
	logic                 rsp_valid_q;
	logic                 rsp_ok_q;
	logic                 rsp_full_q;
	logic [DATA_W-1:0]    rsp_found_q;
	logic [ENTRIES_W-1:0] rsp_entries_q;

	// Walk decode
	logic              node_used;
	logic              node_dead;
	logic              key_eq;
	logic              go_left;
	logic [NEXT_W-1:0] child_idx;
	logic              past_end;
	logic              walk_done;
	logic              slot_free;
	logic              commit;
	logic              accept;

	// Commit decisions
	logic              set_used;
	logic              clr_removed;
	logic              set_removed;
	logic              res_ok;
	logic              res_full;
	logic [DATA_W-1:0] res_found;

	abkvs_node_mem u_node_mem (
		.clk      (clk),
		.wr       (mem_wr),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;

	// One tree level per cycle: compare against the node fetched last cycle
	always_comb begin
		node_used = used_q[idx_q];
		node_dead = removed_q[idx_q];
		key_eq    = (rd_key == key_q);
		go_left   = (key_q < rd_key);
		child_idx = {1'b0, idx_q, 1'b0} + (go_left ? NEXT_W'(1) : NEXT_W'(2));
		past_end  = node_used && !key_eq && (child_idx >= NEXT_W'(NODES));
		walk_done = (mode_q == MODE_NOP) || !node_used || key_eq || past_end;
	end

	// Decide the outcome of a finished walk
	always_comb begin
		set_used    = 1'b0;
		clr_removed = 1'b0;
		set_removed = 1'b0;
		res_ok      = 1'b0;
		res_full    = 1'b0;
		res_found   = '0;
		count_d     = count_q;
		unique case (mode_q)
			MODE_PUT: begin
				if (past_end) begin
					res_full = 1'b1;
				end else if (!node_used) begin
					set_used    = 1'b1;
					clr_removed = 1'b1;
					res_ok      = 1'b1;
					count_d     = count_q + COUNT_W'(1);
				end else if (node_dead) begin
					clr_removed = 1'b1;
					res_ok      = 1'b1;
					count_d     = count_q + COUNT_W'(1);
				end
			end
			MODE_FIND: begin
				if (node_used && key_eq && !node_dead) begin
					res_ok    = 1'b1;
					res_found = DATA_W'(rd_value);
				end
			end
			MODE_REMOVE: begin
				if (node_used && key_eq && !node_dead) begin
					set_removed = 1'b1;
					res_ok      = 1'b1;
					count_d     = count_q - COUNT_W'(1);
				end
			end
			MODE_NOP: begin
			end
		endcase
	end

	// Sequencer: next state, read address and memory write
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		rd_addr   = idx_q;
		req.ready = 1'b0;
		commit    = 1'b0;
		mem_wr    = '{en: 1'b0, addr: idx_q, key: key_q, value: value_q};
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				rd_addr   = '0;
				if (req.valid) begin
					idx_d   = '0;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					// hold on the current node until the response slot frees
					if (slot_free) begin
						commit    = 1'b1;
						mem_wr.en = set_used || clr_removed;
						state_d   = ST_IDLE;
					end
				end else begin
					idx_d   = child_idx[IDX_W-1:0];
					rd_addr = child_idx[IDX_W-1:0];
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Latch the request beat
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode_t'(req.mode);
			key_q   <= req.key;
			value_q <= VALUE_WIDTH'(req.value);
		end
	end

	// Node flags and live count advance only on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			removed_q <= '0;
			count_q   <= '0;
		end else if (commit) begin
			count_q <= count_d;
			if (set_used) begin
				used_q[idx_q] <= 1'b1;
			end
			if (clr_removed) begin
				removed_q[idx_q] <= 1'b0;
			end else if (set_removed) begin
				removed_q[idx_q] <= 1'b1;
			end
		end
	end

	// Response register: load on commit, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_ok_q      <= res_ok;
			rsp_full_q    <= res_full;
			rsp_found_q   <= res_found;
			rsp_entries_q <= ENTRIES_W'(count_d);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.full_res    = rsp_full_q;
	assign rsp.found_value = rsp_found_q;
	assign rsp.entries     = rsp_entries_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(NODES))
		else $error("live count exceeds node count");

	a_rsp_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_WALK))
		else $error("response loaded outside a walk");

	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_ok_q && rsp_full_q))
		else $error("full and ok both set");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && set_removed) |=> (count_q == $past(count_q) - COUNT_W'(1)))
		else $error("remove did not lower the live count");

	a_no_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> slot_free)
		else $error("commit while response slot occupied");
`endif

endmodule

FILE: rtl/core/abkvs_node_mem.sv
// ----------------------------------------------------------------------------
// abkvs_node_mem
// Key and value storage of the tree nodes: one write port, one registered read.
// ----------------------------------------------------------------------------
module abkvs_node_mem (
	input  logic                              clk,
	input  abkvs_pkg::mem_wr_t                wr,
	input  logic [abkvs_pkg::IDX_W-1:0]       rd_addr,
	output logic signed [abkvs_pkg::KEY_W-1:0] rd_key,
	output logic [abkvs_pkg::VALUE_WIDTH-1:0] rd_value
);
	import abkvs_pkg::*;

	logic signed [KEY_W-1:0] key_mem   [NODES];
	logic [VALUE_WIDTH-1:0]  value_mem [NODES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.addr]   <= wr.key;
			value_mem[wr.addr] <= wr.value;
		end
	end

	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_value <= value_mem[rd_addr];
	end

endmodule
